// ===== sv/fqs_pkg.sv =====
// fqs_pkg: shared types, constants and pointer helpers for the searchable fifo queue
// used by fqs_store, fifo_queue_with_search and fqs_checker; depends on nothing

package fqs_pkg;

    // queue geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = 5;
    localparam int WORD_W  = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int MATCH_W = 5;

    // result packing, lowest bit first
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_FRONT_LSB  = OUT_STATUS_LSB + STAT_W;
    localparam int OUT_BACK_LSB   = OUT_FRONT_LSB + WORD_W;
    localparam int OUT_COUNT_LSB  = OUT_BACK_LSB + WORD_W;
    localparam int OUT_MATCH_LSB  = OUT_COUNT_LSB + CNT_W;
    localparam int OUT_USED_W     = OUT_MATCH_LSB + MATCH_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // word reported for front and back of an empty queue
    localparam logic [WORD_W-1:0]  EMPTY_WORD = 32'hFFFF_8000;
    localparam logic [MATCH_W-1:0] NO_MATCH   = '1;
    localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ         = 3'd0,
        MODE_DEQ         = 3'd1,
        MODE_CLEAR       = 3'd2,
        MODE_SRCH_FRONT  = 3'd3,
        MODE_SRCH_BACK   = 3'd4
    } mode_t;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // one result transaction
    typedef struct packed {
        logic [MATCH_W-1:0] match_position;
        logic [CNT_W-1:0]   entry_count;
        logic [WORD_W-1:0]  back_value;
        logic [WORD_W-1:0]  front_value;
        logic [STAT_W-1:0]  status;
    } result_t;

    // access to the ring store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

    // p + n around the ring, n below DEPTH
    function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] p,
                                                 input logic [ADDR_W-1:0] n);
        logic [ADDR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (ADDR_W+1)'(DEPTH))
        begin
            s = s - (ADDR_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    // p - n around the ring, n below DEPTH
    function automatic logic [ADDR_W-1:0] ptr_sub(input logic [ADDR_W-1:0] p,
                                                 input logic [ADDR_W-1:0] n);
        logic [ADDR_W:0] s;
        s = {1'b0, p} - {1'b0, n};
        if (s[ADDR_W])
        begin
            s = s + (ADDR_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/fqs_store.sv =====
// fqs_store: ring store of the queue, one write and one registered read per cycle
// depends on fqs_pkg

module fqs_store
(
    input  logic                          clk,
    input  fqs_pkg::store_req_t           req,
    output logic [fqs_pkg::WORD_W-1:0]    rdata
);

    logic [fqs_pkg::WORD_W-1:0] mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::WORD_W-1:0] rdata_reg;

    // synchronous write and read, read data registered and valid in the next cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fifo_queue_with_search.sv =====
// fifo_queue_with_search: bounded fifo of 32-bit words with search from either end
// depends on fqs_pkg and fqs_store
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value, tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status, front, back, count, match
//
// enqueue, clear, unused modes, search of an empty queue and dequeue that empties or finds
// the queue empty give their result directly; any other dequeue first reads the new front entry.
// a search walks the store one entry per cycle through its single read port, until it
// finds a match or has compared the last held entry.
// reset clears pointers, count and handshake state; store contents need no clearing.
// a new transaction is taken once the previous one is done and the result register
// is free or being drained in the same cycle.

module fifo_queue_with_search
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fqs_pkg::WORD_W-1:0]         s_axis_tdata,  // [31:0] value
    input  logic [fqs_pkg::MODE_W-1:0]         s_axis_tuser,  // [2:0] mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [33:2] front_value, [65:34] back_value, [70:66] entry_count,
    // [75:71] match_position, [79:76] zero
    output logic [fqs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SRCH
    } state_t;

    state_t                          state_reg, state_next;
    logic [fqs_pkg::ADDR_W-1:0]      head_reg, head_next;
    logic [fqs_pkg::ADDR_W-1:0]      tail_reg, tail_next;
    logic [fqs_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [fqs_pkg::WORD_W-1:0]      front_reg, front_next;
    logic [fqs_pkg::WORD_W-1:0]      back_reg, back_next;
    logic [fqs_pkg::WORD_W-1:0]      key_reg, key_next;
    logic                            dir_back_reg, dir_back_next;
    logic [fqs_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic                            out_valid_reg, out_valid_next;
    fqs_pkg::result_t                out_reg, out_next;

    fqs_pkg::store_req_t             store_req;
    logic [fqs_pkg::WORD_W-1:0]      store_rdata;
    logic                            accept;
    logic [fqs_pkg::WORD_W-1:0]      cur_front;
    logic [fqs_pkg::WORD_W-1:0]      cur_back;
    logic [fqs_pkg::ADDR_W-1:0]      idx_inc;
    logic [fqs_pkg::ADDR_W-1:0]      last_ptr;

    fqs_store u_store
    (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    // input side handshake
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // front and back as seen by a result that leaves the queue untouched
    assign cur_front = (count_reg == '0) ? fqs_pkg::EMPTY_WORD : front_reg;
    assign cur_back  = (count_reg == '0) ? fqs_pkg::EMPTY_WORD : back_reg;
    assign idx_inc   = idx_reg + 1'b1;
    assign last_ptr  = fqs_pkg::ptr_sub(tail_reg, fqs_pkg::ADDR_W'(1));

    // operation sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        key_next        = key_reg;
        dir_back_next   = dir_back_reg;
        idx_next        = idx_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        store_req.we    = 1'b0;
        store_req.waddr = tail_reg;
        store_req.wdata = s_axis_tdata;
        store_req.raddr = head_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next                = s_axis_tdata;
                    dir_back_next           = (s_axis_tuser == fqs_pkg::MODE_SRCH_BACK);
                    idx_next                = '0;
                    out_valid_next          = 1'b1;
                    out_next.status         = fqs_pkg::STATUS_OK;
                    out_next.front_value    = cur_front;
                    out_next.back_value     = cur_back;
                    out_next.entry_count    = count_reg;
                    out_next.match_position = fqs_pkg::NO_MATCH;
                    unique case (s_axis_tuser)
                        fqs_pkg::MODE_ENQ:
                        begin
                            if (count_reg == fqs_pkg::FULL_COUNT)
                            begin
                                out_next.status = fqs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                store_req.we         = 1'b1;
                                tail_next            = fqs_pkg::ptr_add(tail_reg,
                                                           fqs_pkg::ADDR_W'(1));
                                count_next           = count_reg + 1'b1;
                                back_next            = s_axis_tdata;
                                out_next.back_value  = s_axis_tdata;
                                out_next.entry_count = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    front_next           = s_axis_tdata;
                                    out_next.front_value = s_axis_tdata;
                                end
                            end
                        end
                        fqs_pkg::MODE_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = fqs_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                head_next            = fqs_pkg::ptr_add(head_reg,
                                                           fqs_pkg::ADDR_W'(1));
                                count_next           = count_reg - 1'b1;
                                out_next.entry_count = count_reg - 1'b1;
                                if (count_reg == fqs_pkg::CNT_W'(1))
                                begin
                                    out_next.front_value = fqs_pkg::EMPTY_WORD;
                                    out_next.back_value  = fqs_pkg::EMPTY_WORD;
                                end
                                else
                                begin
                                    // fetch the new front entry
                                    store_req.raddr = fqs_pkg::ptr_add(head_reg,
                                                          fqs_pkg::ADDR_W'(1));
                                    out_valid_next  = 1'b0;
                                    state_next      = ST_DEQ;
                                end
                            end
                        end
                        fqs_pkg::MODE_CLEAR:
                        begin
                            head_next            = '0;
                            tail_next            = '0;
                            count_next           = '0;
                            out_next.front_value = fqs_pkg::EMPTY_WORD;
                            out_next.back_value  = fqs_pkg::EMPTY_WORD;
                            out_next.entry_count = '0;
                        end
                        fqs_pkg::MODE_SRCH_FRONT,
                        fqs_pkg::MODE_SRCH_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                // first entry from the chosen end
                                store_req.raddr = (s_axis_tuser == fqs_pkg::MODE_SRCH_BACK)
                                                  ? last_ptr : head_reg;
                                out_valid_next  = 1'b0;
                                state_next      = ST_SRCH;
                            end
                        end
                        default:
                        begin
                            // unused mode codes leave the queue as it is
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                front_next              = store_rdata;
                out_valid_next          = 1'b1;
                out_next.status         = fqs_pkg::STATUS_OK;
                out_next.front_value    = store_rdata;
                out_next.back_value     = back_reg;
                out_next.entry_count    = count_reg;
                out_next.match_position = fqs_pkg::NO_MATCH;
                state_next              = ST_IDLE;
            end
            ST_SRCH:
            begin
                out_next.status      = fqs_pkg::STATUS_OK;
                out_next.front_value = cur_front;
                out_next.back_value  = cur_back;
                out_next.entry_count = count_reg;
                if (store_rdata == key_reg)
                begin
                    out_next.match_position = {{(fqs_pkg::MATCH_W-fqs_pkg::ADDR_W){1'b0}},
                                               idx_reg};
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
                else if (fqs_pkg::CNT_W'(idx_reg) + 1'b1 == count_reg)
                begin
                    out_next.match_position = fqs_pkg::NO_MATCH;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    // step to the next entry
                    idx_next        = idx_inc;
                    store_req.raddr = dir_back_reg ? fqs_pkg::ptr_sub(last_ptr, idx_inc)
                                                   : fqs_pkg::ptr_add(head_reg, idx_inc);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, payload and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            dir_back_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            front_reg     <= '0;
            back_reg      <= '0;
            key_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            dir_back_reg  <= dir_back_next;
            out_valid_reg <= out_valid_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            key_reg       <= key_next;
            out_reg       <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(fqs_pkg::OUT_DATA_W-fqs_pkg::OUT_USED_W){1'b0}}, out_reg};

endmodule

// ===== sv/fqs_checker.sv =====
// fqs_checker: port-level assertions for fifo_queue_with_search, bound to the top level
// depends on fqs_pkg

module fqs_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fqs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [fqs_pkg::STAT_W-1:0]  status;
    logic [fqs_pkg::WORD_W-1:0]  front_value;
    logic [fqs_pkg::WORD_W-1:0]  back_value;
    logic [fqs_pkg::CNT_W-1:0]   entry_count;
    logic [fqs_pkg::MATCH_W-1:0] match_position;

    // unpack the result transaction
    assign status         = m_axis_tdata[fqs_pkg::OUT_STATUS_LSB +: fqs_pkg::STAT_W];
    assign front_value    = m_axis_tdata[fqs_pkg::OUT_FRONT_LSB +: fqs_pkg::WORD_W];
    assign back_value     = m_axis_tdata[fqs_pkg::OUT_BACK_LSB +: fqs_pkg::WORD_W];
    assign entry_count    = m_axis_tdata[fqs_pkg::OUT_COUNT_LSB +: fqs_pkg::CNT_W];
    assign match_position = m_axis_tdata[fqs_pkg::OUT_MATCH_LSB +: fqs_pkg::MATCH_W];

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // count never beyond the ring size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> entry_count <= fqs_pkg::FULL_COUNT)
        else $error("entry count beyond depth");

    // an empty queue shows the empty marker at both ends
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && entry_count == '0 |->
            front_value == fqs_pkg::EMPTY_WORD && back_value == fqs_pkg::EMPTY_WORD)
        else $error("empty queue shows stale front or back");

    // a dropped enqueue means the queue was full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == fqs_pkg::STATUS_FULL |->
            entry_count == fqs_pkg::FULL_COUNT)
        else $error("enqueue dropped below full");

    // a match lies within the held entries
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && match_position != fqs_pkg::NO_MATCH |->
            fqs_pkg::CNT_W'(match_position) < entry_count)
        else $error("match position outside queue");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
